FILE: hw/rtl/wit_pkg.sv
`timescale 1ns / 1ps
package wit_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
    localparam int WT_W          = 16 + CNT_W;
    localparam int PROD_W        = 49;
    localparam int MSUM_W        = 48 + CNT_W;
    localparam int DIV_W         = 72;
    localparam int DIV_CNT_W     = $clog2(DIV_W + 1);

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0]        particle_weight;
        logic               last_particle;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] t_xx;
        logic signed [63:0] t_xy;
        logic signed [63:0] t_xz;
        logic signed [63:0] t_yy;
        logic signed [63:0] t_yz;
        logic signed [63:0] t_zz;
        logic               zero_weight_error;
        logic               overflow_flag;
    } t_out_item;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [15:0] w;
    } t_ram_word;

    localparam int RAM_W = $bits(t_ram_word);

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [WT_W-1:0]           wt;
        logic [2:0][MSUM_W-1:0]    msum;
        logic                      ovf;
    } t_set_desc;

    function automatic logic [1:0] pair_a(input logic [2:0] e);
        case (e)
            3'd0, 3'd1, 3'd2: pair_a = 2'd0;
            3'd3, 3'd4:       pair_a = 2'd1;
            default:          pair_a = 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] e);
        case (e)
            3'd0:       pair_b = 2'd0;
            3'd1, 3'd3: pair_b = 2'd1;
            default:    pair_b = 2'd2;
        endcase
    endfunction

endpackage

FILE: hw/rtl/wit_if.sv
`timescale 1ns / 1ps
interface wit_in_if;
    logic              valid;
    logic              ready;
    wit_pkg::t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface wit_out_if;
    logic               valid;
    logic               ready;
    wit_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/wit_ram.sv
`timescale 1ns / 1ps
module wit_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: hw/rtl/wit_front.sv
`timescale 1ns / 1ps
module wit_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wit_in_if.sink                      i_item,
    output logic                        o_we,
    output logic [wit_pkg::ADDR_W-1:0]  o_waddr,
    output wit_pkg::t_ram_word          o_wdata,
    output wit_pkg::t_set_desc          o_desc,
    output logic                        o_desc_valid,
    input  logic                        i_desc_done
);
    logic [wit_pkg::CNT_W-1:0]         r_count;
    logic [wit_pkg::WT_W-1:0]          r_wt, n_wt;
    logic signed [wit_pkg::MSUM_W-1:0] r_msum [3];
    logic signed [wit_pkg::MSUM_W-1:0] n_msum [3];
    logic                              r_ovf, n_ovf;
    logic                              r_hold;
    logic                              r_pv, r_plast, r_pdrop;
    logic signed [wit_pkg::PROD_W-1:0] r_prod [3];
    logic [15:0]                       r_pw;
    logic                              accept, store_ok;

    assign i_item.ready = !r_hold;
    assign accept       = i_item.valid && i_item.ready;
    assign store_ok     = r_count < wit_pkg::CNT_W'(wit_pkg::MAX_PARTICLES);

    assign o_we    = accept && store_ok;
    assign o_waddr = r_count[wit_pkg::ADDR_W-1:0];
    assign o_wdata = '{x: i_item.data.pos_x, y: i_item.data.pos_y,
                       z: i_item.data.pos_z, w: i_item.data.particle_weight};

    always_comb begin
        n_wt  = r_wt;
        n_ovf = r_ovf || r_pdrop;
        for (int k = 0; k < 3; k++) begin
            n_msum[k] = r_msum[k];
        end
        if (r_pv) begin
            n_wt = r_wt + wit_pkg::WT_W'(r_pw);
            for (int k = 0; k < 3; k++) begin
                n_msum[k] = r_msum[k] + wit_pkg::MSUM_W'(r_prod[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw      <= i_item.data.particle_weight;
        r_prod[0] <= i_item.data.pos_x * $signed({1'b0, i_item.data.particle_weight});
        r_prod[1] <= i_item.data.pos_y * $signed({1'b0, i_item.data.particle_weight});
        r_prod[2] <= i_item.data.pos_z * $signed({1'b0, i_item.data.particle_weight});
        if (r_plast) begin
            o_desc.count <= r_count;
            o_desc.wt    <= n_wt;
            o_desc.ovf   <= n_ovf;
            for (int k = 0; k < 3; k++) begin
                o_desc.msum[k] <= n_msum[k];
            end
        end
        if (!i_rst_n) begin
            r_count      <= '0;
            r_wt         <= '0;
            r_ovf        <= 1'b0;
            r_hold       <= 1'b0;
            r_pv         <= 1'b0;
            r_plast      <= 1'b0;
            r_pdrop      <= 1'b0;
            o_desc_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_msum[k] <= '0;
            end
        end else begin
            r_pv    <= accept && store_ok;
            r_pdrop <= accept && !store_ok;
            r_plast <= accept && i_item.data.last_particle;
            if (accept && i_item.data.last_particle) begin
                r_hold <= 1'b1;
            end
            if (o_we) begin
                r_count <= r_count + 1'b1;
            end
            if (r_plast) begin
                r_count      <= '0;
                r_wt         <= '0;
                r_ovf        <= 1'b0;
                o_desc_valid <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    r_msum[k] <= '0;
                end
            end else begin
                r_wt  <= n_wt;
                r_ovf <= n_ovf;
                for (int k = 0; k < 3; k++) begin
                    r_msum[k] <= n_msum[k];
                end
            end
            if (i_desc_done) begin
                o_desc_valid <= 1'b0;
                r_hold       <= 1'b0;
            end
        end
    end
endmodule

FILE: hw/rtl/wit_div.sv
`timescale 1ns / 1ps
module wit_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wit_pkg::DIV_W-1:0]  i_dividend,
    input  logic [wit_pkg::WT_W-1:0]   i_divisor,
    output logic                       o_done,
    output logic [wit_pkg::DIV_W-1:0]  o_quot
);
    logic                          r_busy;
    logic [wit_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [wit_pkg::WT_W-1:0]      r_rem;
    logic [wit_pkg::WT_W-1:0]      r_dvs;
    logic [wit_pkg::WT_W:0]        shifted;
    logic                          qbit;

    assign shifted = {r_rem, o_quot[wit_pkg::DIV_W-1]};
    assign qbit    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            o_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            o_quot <= {o_quot[wit_pkg::DIV_W-2:0], qbit};
            r_rem  <= qbit ? wit_pkg::WT_W'(shifted - {1'b0, r_dvs})
                           : shifted[wit_pkg::WT_W-1:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wit_pkg::DIV_CNT_W'(wit_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wit_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: hw/rtl/wit_back.sv
`timescale 1ns / 1ps
module wit_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wit_pkg::t_set_desc          i_desc,
    input  logic                        i_desc_valid,
    output logic                        o_desc_done,
    input  logic                        i_per_weight,
    output logic [wit_pkg::ADDR_W-1:0]  o_raddr,
    input  wit_pkg::t_ram_word          i_rdata,
    wit_out_if.source                   o_res
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CDIV  = 11'b00000000010,
        S_CWAIT = 11'b00000000100,
        S_RD    = 11'b00000001000,
        S_D     = 11'b00000010000,
        S_M1    = 11'b00000100000,
        S_M2    = 11'b00001000000,
        S_ACC   = 11'b00010000000,
        S_PDIV  = 11'b00100000000,
        S_PWAIT = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state                     r_state;
    logic [1:0]                 r_k;
    logic [2:0]                 r_e;
    logic [wit_pkg::CNT_W-1:0]  r_i, n_i;
    logic signed [33:0]         r_c [3];
    logic [31:0]                r_da [3];
    logic                       r_ds [3];
    logic [15:0]                r_w;
    logic [63:0]                r_p;
    logic                       r_pneg;
    logic [47:0]                r_hi, r_lo;
    logic signed [63:0]         r_acc [6];
    logic                       r_ovf, r_zero;

    logic                       div_start, div_done;
    logic [wit_pkg::DIV_W-1:0]  div_dividend, div_quot;
    logic signed [wit_pkg::MSUM_W-1:0] msum_k;
    logic [wit_pkg::MSUM_W-1:0] msum_mag;
    logic signed [63:0]         acc_e;
    logic [63:0]                acc_mag;
    logic signed [33:0]         cval;
    logic signed [33:0]         dv [3];
    logic [33:0]                dmag [3];
    logic [56:0]                m;
    logic signed [57:0]         t;
    logic signed [64:0]         sum;
    logic signed [63:0]         sat;
    logic                       sat_ovf;
    logic [71:0]                limit;
    logic [63:0]                qsel;
    logic                       q_ovf;

    wit_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (i_desc.wt),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        msum_k   = $signed(i_desc.msum[r_k]);
        msum_mag = msum_k[wit_pkg::MSUM_W-1] ? wit_pkg::MSUM_W'(-msum_k)
                                             : wit_pkg::MSUM_W'(msum_k);
        acc_e    = r_acc[r_e];
        acc_mag  = acc_e[63] ? 64'(-acc_e) : 64'(acc_e);
        div_start = (r_state == S_CDIV) || (r_state == S_PDIV);
        if (r_state == S_CDIV) begin
            div_dividend = {{(wit_pkg::DIV_W - wit_pkg::MSUM_W){1'b0}}, msum_mag};
        end else begin
            div_dividend = {acc_mag, 8'b0};
        end
        cval = msum_k[wit_pkg::MSUM_W-1] ? -$signed(div_quot[33:0])
                                         : $signed(div_quot[33:0]);

        dv[0] = $signed({{2{i_rdata.x[31]}}, i_rdata.x}) - r_c[0];
        dv[1] = $signed({{2{i_rdata.y[31]}}, i_rdata.y}) - r_c[1];
        dv[2] = $signed({{2{i_rdata.z[31]}}, i_rdata.z}) - r_c[2];
        for (int k = 0; k < 3; k++) begin
            dmag[k] = dv[k][33] ? 34'(-dv[k]) : 34'(dv[k]);
        end

        m   = 57'({r_hi, 8'b0}) + 57'(r_lo[47:24]);
        t   = r_pneg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        sum = {acc_e[63], acc_e} + 65'(t);
        sat_ovf = sum[64] != sum[63];
        sat = sat_ovf ? (sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}}) : sum[63:0];

        limit = acc_e[63] ? (72'd1 << 63) : ((72'd1 << 63) - 72'd1);
        q_ovf = div_quot > limit;
        qsel  = q_ovf ? limit[63:0] : div_quot[63:0];

        n_i = r_i + 1'b1;
    end

    assign o_raddr           = r_i[wit_pkg::ADDR_W-1:0];
    assign o_res.valid       = r_state == S_OUT;
    assign o_res.data.t_xx   = r_acc[0];
    assign o_res.data.t_xy   = r_acc[1];
    assign o_res.data.t_xz   = r_acc[2];
    assign o_res.data.t_yy   = r_acc[3];
    assign o_res.data.t_yz   = r_acc[4];
    assign o_res.data.t_zz   = r_acc[5];
    assign o_res.data.zero_weight_error = r_zero;
    assign o_res.data.overflow_flag     = r_ovf;
    assign o_desc_done       = (r_state == S_OUT) && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_desc_valid) begin
                        r_ovf <= i_desc.ovf;
                        r_k   <= 2'd0;
                        r_i   <= '0;
                        for (int e = 0; e < 6; e++) begin
                            r_acc[e] <= '0;
                        end
                        if (i_desc.wt == '0) begin
                            r_zero  <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_zero  <= 1'b0;
                            r_state <= S_CDIV;
                        end
                    end
                end
                S_CDIV: r_state <= S_CWAIT;
                S_CWAIT: begin
                    if (div_done) begin
                        r_c[r_k] <= cval;
                        r_k      <= r_k + 1'b1;
                        r_state  <= (r_k == 2'd2) ? S_RD : S_CDIV;
                    end
                end
                S_RD: r_state <= S_D;
                S_D: begin
                    for (int k = 0; k < 3; k++) begin
                        r_ds[k] <= dv[k][33];
                        r_da[k] <= dmag[k][31:0];
                    end
                    r_w     <= i_rdata.w;
                    r_e     <= 3'd0;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_p     <= r_da[wit_pkg::pair_a(r_e)] * r_da[wit_pkg::pair_b(r_e)];
                    r_pneg  <= r_ds[wit_pkg::pair_a(r_e)] ^ r_ds[wit_pkg::pair_b(r_e)];
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_hi    <= r_p[63:32] * r_w;
                    r_lo    <= r_p[31:0] * r_w;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc[r_e] <= sat;
                    if (sat_ovf) begin
                        r_ovf <= 1'b1;
                    end
                    if (r_e == 3'd5) begin
                        r_i <= n_i;
                        r_e <= 3'd0;
                        if (n_i == i_desc.count) begin
                            r_state <= i_per_weight ? S_PDIV : S_OUT;
                        end else begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_e     <= r_e + 1'b1;
                        r_state <= S_M1;
                    end
                end
                S_PDIV: r_state <= S_PWAIT;
                S_PWAIT: begin
                    if (div_done) begin
                        r_acc[r_e] <= acc_e[63] ? $signed(-qsel) : $signed(qsel);
                        if (q_ovf) begin
                            r_ovf <= 1'b1;
                        end
                        r_e     <= r_e + 1'b1;
                        r_state <= (r_e == 3'd5) ? S_OUT : S_PDIV;
                    end
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hw/rtl/weighted_inertia_tensor_unit.sv
`timescale 1ns / 1ps
// Load: one particle per cycle, ready stays high until the last item of a set.
// Compute after the last item: three centroid divides on the 72-step shared divider, then a walk
// over the N stored particles, plus six divides in per-weight mode on the same divider.
// One set at a time: the particle store is reused, so loading resumes after the result transfer.
// Synchronous active-low reset clears counts, sums and control; per-weight mode resets to 1.
module weighted_inertia_tensor_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    wit_in_if.sink    i_item,
    wit_out_if.source o_res
);
    logic                       r_per_weight;
    logic                       we;
    logic [wit_pkg::ADDR_W-1:0] waddr, raddr;
    wit_pkg::t_ram_word         wdata, rdata;
    wit_pkg::t_set_desc         desc;
    logic                       desc_valid, desc_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_per_weight <= 1'b1;
        end else if (i_cfg_we) begin
            r_per_weight <= i_cfg_wdata;
        end
    end

    wit_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_desc       (desc),
        .o_desc_valid (desc_valid),
        .i_desc_done  (desc_done)
    );

    wit_ram #(
        .W (wit_pkg::RAM_W),
        .D (wit_pkg::MAX_PARTICLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    wit_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (desc),
        .i_desc_valid (desc_valid),
        .o_desc_done  (desc_done),
        .i_per_weight (r_per_weight),
        .o_raddr      (raddr),
        .i_rdata      (rdata),
        .o_res        (o_res)
    );
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SAT_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    wit_in_if  particle_if ();
    wit_out_if tensor_if ();

    weighted_inertia_tensor_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (particle_if.sink),
        .o_res       (tensor_if.source)
    );

    // predictor state
    logic signed [31:0] px_mem [wit_pkg::MAX_PARTICLES];
    logic signed [31:0] py_mem [wit_pkg::MAX_PARTICLES];
    logic signed [31:0] pz_mem [wit_pkg::MAX_PARTICLES];
    logic [15:0]        pw_mem [wit_pkg::MAX_PARTICLES];
    int                 set_count;
    longint unsigned    set_weight;
    longint             set_moment [3];
    bit                 set_dropped;
    bit                 divide_mode;

    wit_pkg::t_out_item tensor_q [$];
    int        fail_count;
    int        sender_idle_pct;
    int        receiver_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("weighted_inertia_tensor_unit regression: fail");
        $finish;
    end

    function automatic longint weighted_term(longint a, longint b, logic [15:0] w);
        longint unsigned ua, ub, p, lo, hi, m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ua = (a < 0) ? -a : a;
        ub = (b < 0) ? -b : b;
        p = ua * ub;
        lo = (p & 64'hFFFF_FFFF) * w;
        hi = (p >> 32) * w;
        m = (hi << 8) + (lo >> 24);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint sat_add(longint a, longint t, inout bit ovf);
        logic signed [64:0] s;
        s = {a[63], a} + {t[63], t};
        if (s[64] != s[63]) begin
            ovf = 1'b1;
            return (t > 0) ? SAT_MAX : SAT_MIN;
        end
        return s[63:0];
    endfunction

    function automatic longint per_weight_div(longint acc, longint unsigned wsum,
                                              inout bit ovf);
        longint unsigned mag, qh, r, lim, q;
        bit neg;
        neg = acc < 0;
        mag = neg ? 64'd0 - acc : acc;
        qh = mag / wsum;
        r = mag % wsum;
        lim = neg ? (64'd1 << 63) : ((64'd1 << 63) - 1);
        if (qh >= (64'd1 << 56)) begin
            q = lim;
            ovf = 1'b1;
        end else begin
            q = (qh << 8) + (r << 8) / wsum;
            if (q > lim) begin
                q = lim;
                ovf = 1'b1;
            end
        end
        if (!neg) return longint'(q);
        if (q == (64'd1 << 63)) return SAT_MIN;
        return -longint'(q);
    endfunction

    task automatic clear_set();
        set_count = 0;
        set_weight = 0;
        for (int k = 0; k < 3; k++) set_moment[k] = 0;
        set_dropped = 1'b0;
    endtask

    task automatic absorb_particle(wit_pkg::t_in_item it);
        wit_pkg::t_out_item res;
        longint c [3];
        longint d [3];
        longint acc [6];
        longint v;
        bit ovf;
        int ea [6];
        int eb [6];
        ea = '{0, 0, 0, 1, 1, 2};
        eb = '{0, 1, 2, 1, 2, 2};
        if (set_count < wit_pkg::MAX_PARTICLES) begin
            px_mem[set_count] = it.pos_x;
            py_mem[set_count] = it.pos_y;
            pz_mem[set_count] = it.pos_z;
            pw_mem[set_count] = it.particle_weight;
            set_count++;
            set_weight += it.particle_weight;
            set_moment[0] += longint'(it.pos_x) * longint'(it.particle_weight);
            set_moment[1] += longint'(it.pos_y) * longint'(it.particle_weight);
            set_moment[2] += longint'(it.pos_z) * longint'(it.particle_weight);
        end else begin
            set_dropped = 1'b1;
        end
        if (!it.last_particle) return;
        res = '0;
        ovf = set_dropped;
        if (set_weight == 0) begin
            res.zero_weight_error = 1'b1;
        end else begin
            for (int k = 0; k < 3; k++) c[k] = set_moment[k] / longint'(set_weight);
            for (int e = 0; e < 6; e++) acc[e] = 0;
            for (int i = 0; i < set_count; i++) begin
                d[0] = longint'(px_mem[i]) - c[0];
                d[1] = longint'(py_mem[i]) - c[1];
                d[2] = longint'(pz_mem[i]) - c[2];
                for (int e = 0; e < 6; e++)
                    acc[e] = sat_add(acc[e], weighted_term(d[ea[e]], d[eb[e]], pw_mem[i]),
                                     ovf);
            end
            for (int e = 0; e < 6; e++) begin
                v = acc[e];
                if (divide_mode) v = per_weight_div(v, set_weight, ovf);
                acc[e] = v;
            end
            res.t_xx = acc[0];
            res.t_xy = acc[1];
            res.t_xz = acc[2];
            res.t_yy = acc[3];
            res.t_yz = acc[4];
            res.t_zz = acc[5];
        end
        res.overflow_flag = ovf;
        tensor_q.push_back(res);
        clear_set();
    endtask

    task automatic check_field(string name, longint expv, longint actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        tensor_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        wit_pkg::t_out_item e;
        wit_pkg::t_out_item a;
        if (i_rst_n && tensor_if.valid && tensor_if.ready) begin
            a = tensor_if.data;
            if (tensor_q.size() == 0) begin
                $error("unexpected result transfer");
                fail_count++;
            end else begin
                e = tensor_q.pop_front();
                check_field("t_xx", e.t_xx, a.t_xx);
                check_field("t_xy", e.t_xy, a.t_xy);
                check_field("t_xz", e.t_xz, a.t_xz);
                check_field("t_yy", e.t_yy, a.t_yy);
                check_field("t_yz", e.t_yz, a.t_yz);
                check_field("t_zz", e.t_zz, a.t_zz);
                check_field("zero_weight_error", e.zero_weight_error, a.zero_weight_error);
                check_field("overflow_flag", e.overflow_flag, a.overflow_flag);
            end
        end
    end

    task automatic send_particle(wit_pkg::t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            particle_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        particle_if.valid <= 1'b1;
        particle_if.data  <= it;
        do @(posedge i_clk); while (!particle_if.ready);
        absorb_particle(it);
    endtask

    task automatic drain_results();
        particle_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tensor_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_mode(bit v);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        divide_mode = v;
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(512));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic wit_pkg::t_in_item make_particle(logic [31:0] x, logic [31:0] y,
                                                        logic [31:0] z, logic [15:0] w,
                                                        bit last);
        wit_pkg::t_in_item it;
        it.pos_x = x;
        it.pos_y = y;
        it.pos_z = z;
        it.particle_weight = w;
        it.last_particle = last;
        return it;
    endfunction

    task automatic test_directed();
        for (int m = 1; m >= 0; m--) begin
            write_mode(m[0]);
            send_particle(make_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 16'hFFFF,
                                        1'b1));
            send_particle(make_particle(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        16'hFFFF, 1'b0));
            send_particle(make_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                        16'd1, 1'b1));
            send_particle(make_particle(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000,
                                        16'd0, 1'b0));
            send_particle(make_particle(32'h1234_5678, 32'h8765_4321, 32'hFFFF_FFFF,
                                        16'd0, 1'b1));
            send_particle(make_particle(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                        16'h0100, 1'b0));
            send_particle(make_particle(32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFD_0000,
                                        16'h0300, 1'b1));
        end
    endtask

    // full store with extreme positions: entries saturate, tail items are dropped
    task automatic test_store_full();
        write_mode(1'b1);
        for (int i = 0; i < wit_pkg::MAX_PARTICLES + 6; i++)
            send_particle(make_particle(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                                        i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                        i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                                        16'hFFFF, i == wit_pkg::MAX_PARTICLES + 5));
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, bit mode);
        int len;
        write_mode(mode);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < 40; ) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
                send_particle(make_particle(rand_pos(), rand_pos(), rand_pos(),
                                            rand_weight(), i == len - 1));
            n += len;
            if ($urandom_range(15) == 0) drain_results();
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        particle_if.valid = 1'b0;
        particle_if.data = '0;
        fail_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        divide_mode = 1'b1;
        clear_set();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_store_full();
        test_random_phase(0, 0, 1'b1);
        test_random_phase(62, 0, 1'b0);
        test_random_phase(0, 62, 1'b1);
        test_random_phase(38, 38, 1'b0);
        drain_results();
        if (fail_count == 0 && tensor_q.size() == 0) begin
            $display("weighted_inertia_tensor_unit regression: pass");
        end else begin
            $display("weighted_inertia_tensor_unit regression: fail");
        end
        $finish;
    end

endmodule
